@@ rtl/core/rfr_pkg.sv @@
// Shared types and constants for the ranging frame receiver.
// No dependencies; every other file of the block imports this package.
package rfr_pkg;

  // Defaults for the configuration registers and the tick period
  localparam int unsigned TICK_PERIOD_MS_DEF = 10;
  localparam logic [15:0] REPLY_WAIT_RST     = 16'd2000;
  localparam logic [15:0] MAX_DISTANCE_RST   = 16'd4500;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLY_WAIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;

  // Request kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // Frame phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_CHK  = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_GOOD    = 3'd1;
  localparam logic [2:0] EV_RANGE   = 3'd2;
  localparam logic [2:0] EV_CHKERR  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } rfr_in_t;

  typedef struct packed {
    logic        send_trigger;
    logic [2:0]  event_res;
    logic [15:0] distance_mm;
    logic        reading_valid;
    logic [15:0] checksum_errors;
  } rfr_out_t;

  typedef struct packed {
    logic [15:0] reply_wait_ms;
    logic [15:0] max_distance;
  } rfr_cfg_t;

endpackage

@@ rtl/core/rfr_cfg_regs.sv @@
// Configuration registers of the ranging frame receiver.
// Depends on rfr_pkg for the register indexes and reset values.
module rfr_cfg_regs
  import rfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rfr_cfg_t              cfg
);

  rfr_cfg_t cfg_r, cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_REPLY_WAIT:   cfg_nxt.reply_wait_ms = cfg_wdata;
        CFG_MAX_DISTANCE: cfg_nxt.max_distance  = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_wait_ms <= REPLY_WAIT_RST;
      cfg_r.max_distance  <= MAX_DISTANCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/rfr_frame_core.sv @@
// Frame state, tick counting and reply checking of the ranging frame receiver.
// Depends on rfr_pkg; updates its state on every accepted request.
module rfr_frame_core
  import rfr_pkg::*;
#(
  parameter int unsigned TICK_PERIOD_MS = TICK_PERIOD_MS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  rfr_in_t  req,
  input  rfr_cfg_t cfg,
  output rfr_out_t res
);

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned PROD_W = CNT_W + $clog2(TICK_PERIOD_MS + 1);

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] errs_r, errs_nxt;

  logic [15:0]       ticks_inc;
  logic [CNT_W-1:0]  ticks_p1;
  logic [PROD_W-1:0] tick_span;
  logic              timed_out;
  logic [7:0]        sum;
  logic [15:0]       value;
  logic              trig;
  logic [2:0]        ev;

  // Count >= timeout/period  <=>  (count + 1) * period > timeout
  assign ticks_inc = ticks_r + 16'd1;
  assign ticks_p1  = {1'b0, ticks_inc} + CNT_W'(1);
  assign tick_span = PROD_W'(ticks_p1) * PROD_W'(TICK_PERIOD_MS);
  assign timed_out = tick_span > PROD_W'(cfg.reply_wait_ms);

  assign sum   = high_r + low_r;
  assign value = {high_r, low_r};

  // Next state and event for one request
  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    ticks_nxt = ticks_r;
    dist_nxt  = dist_r;
    valid_nxt = valid_r;
    errs_nxt  = errs_r;
    trig      = 1'b0;
    ev        = EV_NONE;
    if (req.opcode == OP_TICK) begin
      if (phase_r == PH_IDLE) begin
        ticks_nxt = '0;
        trig      = 1'b1;
        phase_nxt = PH_HIGH;
      end else if (timed_out) begin
        phase_nxt = PH_IDLE;
        ticks_nxt = '0;
        valid_nxt = 1'b0;
        ev        = EV_TIMEOUT;
      end else begin
        ticks_nxt = ticks_inc;
      end
    end else begin
      case (phase_r)
        PH_HIGH: begin
          high_nxt  = req.rx_byte;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          low_nxt   = req.rx_byte;
          phase_nxt = PH_CHK;
        end
        PH_CHK: begin
          phase_nxt = PH_IDLE;
          if (sum != req.rx_byte) begin
            errs_nxt  = errs_r + 16'd1;
            valid_nxt = 1'b0;
            ev        = EV_CHKERR;
          end else if (value <= cfg.max_distance) begin
            dist_nxt  = value;
            valid_nxt = 1'b1;
            ev        = EV_GOOD;
          end else begin
            valid_nxt = 1'b0;
            ev        = EV_RANGE;
          end
        end
        default: begin
          // byte while idle is ignored
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      high_r  <= '0;
      low_r   <= '0;
      ticks_r <= '0;
      dist_r  <= '0;
      valid_r <= 1'b0;
      errs_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      ticks_r <= ticks_nxt;
      dist_r  <= dist_nxt;
      valid_r <= valid_nxt;
      errs_r  <= errs_nxt;
    end
  end

  // Result reflects the state after this request
  always_comb begin
    res.send_trigger    = trig;
    res.event_res       = ev;
    res.distance_mm     = dist_nxt;
    res.reading_valid   = valid_nxt;
    res.checksum_errors = errs_nxt;
  end

endmodule

@@ rtl/core/rfr_out_buf.sv @@
// Two-entry result buffer: output register plus skid stage.
// Depends on rfr_pkg for the result type.
module rfr_out_buf
  import rfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rfr_out_t push_data,
  output logic     can_push,
  output logic     out_valid,
  input  logic     out_ready,
  output rfr_out_t out_data
);

  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  rfr_out_t main_r, main_nxt;
  rfr_out_t skid_r, skid_nxt;
  logic     pop;

  assign pop      = main_valid_r & out_ready;
  assign can_push = ~skid_valid_r;

  // A push only happens while the skid stage is empty
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

@@ rtl/core/ranging_frame_receiver.sv @@
// Ranging frame receiver: trigger/timeout control and reply frame checking.
// Top level; depends on rfr_pkg, rfr_cfg_regs, rfr_frame_core, rfr_out_buf.
//
// Usage:
//   The in_ channel carries requests: a timer tick (opcode 0) or a received
//   byte (opcode 1). Every request yields exactly one result on the out_
//   channel: trigger request, event code, latest distance, valid flag and
//   checksum error count, all as they stand after that request.
//   Results are registered in the output buffer. Throughput is one request
//   per cycle while in_ready is high; the state update and checks of one
//   request are combinational, the timeout compare being one small
//   constant multiply and a 21-bit compare. When the receiver stalls, the
//   output register and a skid entry hold up to two results; in_ready falls
//   only once both are occupied. Configuration (reply wait in ms at index 0,
//   max_distance at index 1) is written through cfg_we/cfg_index/cfg_wdata;
//   the user writes it only while idle, which the block does not enforce.
//   Synchronous reset (rst_n low) returns to idle, clears all counters,
//   the distance and the valid flag, empties the result buffer and loads
//   a reply wait of 2000 ms and max_distance 4500.
module ranging_frame_receiver
  import rfr_pkg::*;
#(
  parameter int unsigned TICK_PERIOD_MS = TICK_PERIOD_MS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rfr_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rfr_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rfr_cfg_t cfg;
  rfr_out_t res;
  logic     step;

  assign step = in_valid & in_ready;

  // Configuration registers
  rfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Frame state and checks
  rfr_frame_core #(
    .TICK_PERIOD_MS (TICK_PERIOD_MS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .req   (in_data),
    .cfg   (cfg),
    .res   (res)
  );

  // Result buffer
  rfr_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // Skid entry is only ever filled behind a full output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output register");

  // A trigger request never comes with an event
  a_trig_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.send_trigger) |-> (out_data.event_res == EV_NONE))
    else $error("trigger request carries an event");

  // Event code agrees with the valid flag
  a_event_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.event_res != EV_NONE) |->
      (out_data.reading_valid == (out_data.event_res == EV_GOOD)))
    else $error("valid flag disagrees with event");

  // A request accepted while the output register is stalled fills the skid entry
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (step && out_valid && !out_ready) |=> !in_ready)
    else $error("skid entry not filled on stalled request");
`endif

endmodule
